// File: rtl/exponential_backoff_retry_timer_core_macros.svh
// Assertion macros for the exponential backoff retry timer core.
`ifndef EXPONENTIAL_BACKOFF_RETRY_TIMER_CORE_MACROS_SVH
`define EXPONENTIAL_BACKOFF_RETRY_TIMER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define EBRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EBRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ebrt_pkg.sv
// Shared types and constants for the exponential backoff retry timer core.
`default_nettype none

package ebrt_pkg;

  localparam int DELAY_BITS_DEF = 24;

  localparam int GROW_BITS   = 11;
  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int FACT_BITS   = 17;
  localparam int CNT_BITS    = 16;
  localparam int GROW_FRAC   = 8;
  localparam int FACT_SHIFT  = 15;
  localparam int STEP_BITS   = 5;
  localparam int CMD_BITS    = 2;
  localparam int IDX_BITS    = 3;

  localparam logic [FACT_BITS-1:0] FACT_ONE = 17'h10000;

  localparam int RETRY_EN_RST   = 1;
  localparam int INIT_DELAY_RST = 1000;
  localparam int MAX_DELAY_RST  = 30000;
  localparam int GROWTH_RST     = 512;
  localparam int JITTER_EN_RST  = 1;
  localparam int FRAC_RST       = 16384;
  localparam int LIMIT_RST      = 0;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_REQUEST   = 2'd0,
    CMD_RESET_ATT = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_CANCEL    = 2'd3
  } cmd_t;

  localparam logic [IDX_BITS-1:0] REG_RETRY_EN  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_INIT      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_MAX       = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_GROWTH    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_JITTER_EN = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_FRAC      = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_LIMIT     = 3'd6;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_BASE = 6'b000100,
    ST_JMUL = 6'b001000,
    ST_ARM  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/exponential_backoff_retry_timer_core.sv
// Capped exponential backoff retry timer with jitter, bit-serial datapath.
//
// One beat in gives one beat out. Tick, reset-attempts, cancel and refused
// request beats go straight from idle to loading the result. An allowed retry
// request runs the bit-serial multiply of the growth product and the jitter
// factor side by side, settles the base delay, with jitter shifts the
// jittered product out, then arms the countdown and loads the result. A new
// input beat is taken once the result register has been loaded, even while
// that result still waits downstream. The user must write configuration
// through the cfg port while the core is idle; the core does not enforce it.
`default_nettype none

module exponential_backoff_retry_timer_core
  import ebrt_pkg::*;
#(
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  localparam int OUT_BITS  = 2 * DELAY_BITS + 20,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_BITS-1:0] in_tdata,   // [15:0] jitter_sample
  input  wire logic [CMD_BITS-1:0]    in_tuser,   // [1:0] command
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // delay_ms, remaining_ms, expired, timer_active, attempts_made, may_retry, zero pad
  output logic [OUT_W-1:0]            out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [IDX_BITS-1:0]    cfg_index,
  input  wire logic [DELAY_BITS-1:0]  cfg_data
);

  localparam int GP_W    = DELAY_BITS + GROW_BITS;
  localparam int FP_W    = 2 * FRAC_BITS;
  localparam int JP_W    = DELAY_BITS + FACT_BITS;
  localparam int EXP_POS = 2 * DELAY_BITS;
  localparam int ACT_POS = 2 * DELAY_BITS + 1;

  // configuration
  logic                  retry_en_r, retry_en_nxt;
  logic [DELAY_BITS-1:0] init_r, init_nxt;
  logic [DELAY_BITS-1:0] max_r, max_nxt;
  logic [GROW_BITS-1:0]  growth_r, growth_nxt;
  logic                  jit_en_r, jit_en_nxt;
  logic [FRAC_BITS-1:0]  frac_r, frac_nxt;
  logic [CNT_BITS-1:0]   limit_r, limit_nxt;

  // timer state
  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [DELAY_BITS-1:0] base_r, base_nxt;
  logic [DELAY_BITS-1:0] cdown_r, cdown_nxt;
  logic                  armed_r, armed_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic                  first_r, first_nxt;
  logic                  jit_r, jit_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;

  // serial product registers
  logic [GP_W-1:0]       gp_r, gp_nxt;
  logic [FP_W-1:0]       fp_r, fp_nxt;
  logic [JP_W-1:0]       jp_r, jp_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic                  allowed;
  logic [DELAY_BITS:0]   gsum, jsum;
  logic [FRAC_BITS:0]    fsum;
  logic [DELAY_BITS+2:0] grown;
  logic [DELAY_BITS-1:0] capped, base_new;
  logic [FACT_BITS:0]    fact_sum;
  logic [DELAY_BITS:0]   jraw, jfloor;
  logic [DELAY_BITS-1:0] jclamp, arm_val;
  logic [SAMPLE_BITS-1:0] ubias;
  logic                  out_free;

  assign allowed   = retry_en_r && ((limit_r == '0) || (cnt_r < limit_r));
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // one bit per cycle through each product
  assign gsum = {1'b0, gp_r[GP_W-1 -: DELAY_BITS]} + (gp_r[0] ? {1'b0, base_r} : '0);
  assign fsum = {1'b0, fp_r[FP_W-1 -: FRAC_BITS]} + (fp_r[0] ? {1'b0, frac_r} : '0);
  assign jsum = {1'b0, jp_r[JP_W-1 -: DELAY_BITS]} + (jp_r[0] ? {1'b0, base_r} : '0);

  assign grown    = gp_r[GP_W-1:GROW_FRAC];
  assign capped   = (grown > {3'b0, max_r}) ? max_r : grown[DELAY_BITS-1:0];
  assign base_new = first_r ? init_r : capped;

  // frac*s + 2^31 = frac*(s+2^15) + (2^16-frac)*2^15
  assign ubias    = {~in_tdata[SAMPLE_BITS-1], in_tdata[SAMPLE_BITS-2:0]};
  assign fact_sum = {1'b0, fp_r[FP_W-1:FACT_SHIFT]} + {1'b0, FACT_ONE - {1'b0, frac_r}};

  assign jraw    = jp_r[JP_W-1 -: (DELAY_BITS + 1)];
  assign jfloor  = (jraw == '0) ? (DELAY_BITS + 1)'(1) : jraw;
  assign jclamp  = (jfloor > {1'b0, max_r}) ? max_r : jfloor[DELAY_BITS-1:0];
  assign arm_val = jit_r ? jclamp : delay_r;

  always_comb begin
    retry_en_nxt  = retry_en_r;
    init_nxt      = init_r;
    max_nxt       = max_r;
    growth_nxt    = growth_r;
    jit_en_nxt    = jit_en_r;
    frac_nxt      = frac_r;
    limit_nxt     = limit_r;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    cdown_nxt     = cdown_r;
    armed_nxt     = armed_r;
    delay_nxt     = delay_r;
    first_nxt     = first_r;
    jit_nxt       = jit_r;
    step_nxt      = step_r;
    gp_nxt        = gp_r;
    fp_nxt        = fp_r;
    jp_nxt        = jp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_RETRY_EN:  retry_en_nxt = cfg_data[0];
        REG_INIT:      init_nxt     = cfg_data;
        REG_MAX:       max_nxt      = cfg_data;
        REG_GROWTH:    growth_nxt   = cfg_data[GROW_BITS-1:0];
        REG_JITTER_EN: jit_en_nxt   = cfg_data[0];
        REG_FRAC:      frac_nxt     = cfg_data[FRAC_BITS-1:0];
        REG_LIMIT:     limit_nxt    = cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          delay_nxt = '0;
          jit_nxt   = 1'b0;
          state_nxt = ST_FIN;
          unique case (cmd_t'(in_tuser))
            CMD_REQUEST: begin
              if (!allowed) begin
                armed_nxt = 1'b0;
              end else begin
                first_nxt = (cnt_r == '0);
                if (cnt_r != '1) begin
                  cnt_nxt = cnt_r + 1'b1;
                end
                gp_nxt    = {{DELAY_BITS{1'b0}}, growth_r};
                fp_nxt    = {{FRAC_BITS{1'b0}}, ubias};
                step_nxt  = '0;
                state_nxt = ST_MUL;
              end
            end
            CMD_RESET_ATT: cnt_nxt = '0;
            CMD_TICK: begin
              if (armed_r && (cdown_r != '0)) begin
                cdown_nxt = cdown_r - 1'b1;
              end
            end
            CMD_CANCEL: armed_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        fp_nxt = {fsum, fp_r[FRAC_BITS-1:1]};
        if (step_r < STEP_BITS'(GROW_BITS)) begin
          gp_nxt = {gsum, gp_r[GROW_BITS-1:1]};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(FRAC_BITS - 1)) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        base_nxt = base_new;
        if (jit_en_r && (frac_r != '0)) begin
          jit_nxt   = 1'b1;
          jp_nxt    = {{DELAY_BITS{1'b0}}, fact_sum[FACT_BITS-1:0]};
          step_nxt  = '0;
          state_nxt = ST_JMUL;
        end else begin
          delay_nxt = base_new;
          state_nxt = ST_ARM;
        end
      end
      ST_JMUL: begin
        jp_nxt   = {jsum, jp_r[FACT_BITS-1:1]};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(FACT_BITS - 1)) begin
          state_nxt = ST_ARM;
        end
      end
      ST_ARM: begin
        delay_nxt = arm_val;
        if (arm_val != '0) begin
          cdown_nxt = arm_val;
          armed_nxt = 1'b1;
        end else begin
          armed_nxt = 1'b0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({allowed, cnt_r, armed_r,
                                  armed_r && (cdown_r == '0),
                                  (armed_r ? cdown_r : {DELAY_BITS{1'b0}}), delay_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_en_r  <= 1'(RETRY_EN_RST);
      init_r      <= DELAY_BITS'(INIT_DELAY_RST);
      max_r       <= DELAY_BITS'(MAX_DELAY_RST);
      growth_r    <= GROW_BITS'(GROWTH_RST);
      jit_en_r    <= 1'(JITTER_EN_RST);
      frac_r      <= FRAC_BITS'(FRAC_RST);
      limit_r     <= CNT_BITS'(LIMIT_RST);
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      cdown_r     <= '0;
      armed_r     <= 1'b0;
      first_r     <= 1'b0;
      jit_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      retry_en_r  <= retry_en_nxt;
      init_r      <= init_nxt;
      max_r       <= max_nxt;
      growth_r    <= growth_nxt;
      jit_en_r    <= jit_en_nxt;
      frac_r      <= frac_nxt;
      limit_r     <= limit_nxt;
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      cdown_r     <= cdown_nxt;
      armed_r     <= armed_nxt;
      first_r     <= first_nxt;
      jit_r       <= jit_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delay_r    <= delay_nxt;
    gp_r       <= gp_nxt;
    fp_r       <= fp_nxt;
    jp_r       <= jp_nxt;
    out_data_r <= out_data_nxt;
  end

`include "exponential_backoff_retry_timer_core_macros.svh"

  `EBRT_ASSERT_IMP(a_expired_active, out_tvalid && out_tdata[EXP_POS], out_tdata[ACT_POS], "expired flag set on an idle timer")
  `EBRT_ASSERT_NXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready, "input taken while a beat is in work")
  `EBRT_ASSERT_IMP(a_mul_step, state_r == ST_MUL, step_r < STEP_BITS'(FRAC_BITS), "serial step count overran")

endmodule

`default_nettype wire
